// File: design/aabbs_pkg.sv
// Shared types, register indexes, reset values and codes for the box body step unit.
package aabbs_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd6;

    // Register reset values.
    localparam logic signed [23:0] GRAVITY_X_RST   = 24'sd0;
    localparam logic signed [23:0] GRAVITY_Y_RST   = 24'sd4096;
    localparam logic [15:0]        DRAG_FACTOR_RST = 16'd0;
    localparam logic [11:0]        BODY_WIDTH_RST  = 12'd16;
    localparam logic [11:0]        BODY_HEIGHT_RST = 12'd16;
    localparam logic signed [15:0] START_X_RST     = 16'sd0;
    localparam logic signed [15:0] START_Y_RST     = 16'sd0;

    // Item commands.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_COLLIDE = 1'b1;

    // Block face codes.
    localparam logic [2:0] EDGE_NONE   = 3'd0;
    localparam logic [2:0] EDGE_TOP    = 3'd1;
    localparam logic [2:0] EDGE_RIGHT  = 3'd2;
    localparam logic [2:0] EDGE_BOTTOM = 3'd3;
    localparam logic [2:0] EDGE_LEFT   = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic signed [15:0] block_x;
        logic signed [15:0] block_y;
        logic [11:0]        block_w;
        logic [11:0]        block_h;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         hit_edge;
        logic signed [15:0] body_x;
        logic signed [15:0] body_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] acc_x;
        logic signed [23:0] acc_y;
    } t_body_state;

    typedef struct packed {
        logic signed [23:0] gravity_x;
        logic signed [23:0] gravity_y;
        logic [15:0]        drag_factor;
        logic [11:0]        body_width;
        logic [11:0]        body_height;
    } t_cfg;

endpackage

// File: design/aabb_body_step_and_collision_top.sv
// Top level of the box body step and collision unit: channels, registers and state.
//
//  Channel  Signals                                  Direction
//  in       i_in_valid, o_in_stall, i_in_data        item in (tick or collide)
//  out      o_out_valid, i_out_stall, o_out_data     one result per item
//  cfg      i_cfg_we, i_cfg_idx, i_cfg_data          register writes
//
// One item per cycle is sustained while the output is not stalled. Each item is held in
// the input register, and the body state is read and rewritten as it passes on to the
// result register that offers its result; each item sees the state left by the one
// before. Reset is synchronous; it restores registers and body state.
// A stalled output holds its result while one more item waits in the input register.
module aabb_body_step_and_collision_top #(
    parameter int FRAC_BITS = aabbs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  aabbs_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output aabbs_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [aabbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aabbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import aabbs_pkg::*;

    t_cfg        r_cfg;
    t_body_state r_state;
    t_body_state n_state;
    t_out_item   n_result;
    logic        r_a_valid;
    t_in_item    r_a_item;
    logic        r_b_valid;
    t_out_item   r_b_item;
    logic        advance;
    logic        in_xfer;

    assign advance    = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_b_valid;
    assign o_out_data  = r_b_item;

    aabbs_step #(
        .FRAC_BITS(FRAC_BITS)
    ) u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_a_item),
        .o_state (n_state),
        .o_result(n_result)
    );

    // Configuration registers. The start position only matters at reset, where it
    // always holds its reset value, so writes to it need no storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_x   <= GRAVITY_X_RST;
            r_cfg.gravity_y   <= GRAVITY_Y_RST;
            r_cfg.drag_factor <= DRAG_FACTOR_RST;
            r_cfg.body_width  <= BODY_WIDTH_RST;
            r_cfg.body_height <= BODY_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAVITY_X:   r_cfg.gravity_x   <= i_cfg_data;
                CFG_GRAVITY_Y:   r_cfg.gravity_y   <= i_cfg_data;
                CFG_DRAG_FACTOR: r_cfg.drag_factor <= i_cfg_data[15:0];
                CFG_BODY_WIDTH:  r_cfg.body_width  <= i_cfg_data[11:0];
                CFG_BODY_HEIGHT: r_cfg.body_height <= i_cfg_data[11:0];
                CFG_START_X, CFG_START_Y: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Body state and handshake control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos_x <= START_X_RST;
            r_state.pos_y <= START_Y_RST;
            r_state.vel_x <= 24'sd0;
            r_state.vel_y <= 24'sd0;
            r_state.acc_x <= 24'sd0;
            r_state.acc_y <= 24'sd0;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            r_a_valid <= in_xfer || (r_a_valid && !advance);
            r_b_valid <= advance || (r_b_valid && i_out_stall);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_item <= i_in_data;
        end
        if (advance) begin
            r_b_item <= n_result;
        end
    end

endmodule

// File: design/aabbs_step.sv
// Next-state and result logic for one tick or collision item.
module aabbs_step #(
    parameter int FRAC_BITS = aabbs_pkg::FRAC_BITS_DEF
) (
    input  aabbs_pkg::t_body_state i_state,
    input  aabbs_pkg::t_cfg        i_cfg,
    input  aabbs_pkg::t_in_item    i_item,
    output aabbs_pkg::t_body_state o_state,
    output aabbs_pkg::t_out_item   o_result
);
    import aabbs_pkg::*;

    // Width of a previous-centre offset at doubled, fixed-point scale.
    localparam int DW = FRAC_BITS + 21;
    localparam int PW = DW + 15;

    localparam logic signed [31:0] ONE_Q     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] NEG_ONE_Q = -(32'sd1 <<< FRAC_BITS);
    localparam logic signed [24:0] VBIAS     = 25'((32'sd1 <<< FRAC_BITS) - 32'sd1);
    localparam logic signed [40:0] DBIAS     = 41'sd65535;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -25'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ---------------- tick ----------------
    logic signed [24:0] acc_x_sum, acc_y_sum;
    logic signed [23:0] acc_x_new, acc_y_new;
    logic signed [16:0] drag_s;
    logic signed [40:0] dprod_x, dprod_y, dadj_x, dadj_y;
    logic signed [23:0] drag_x, drag_y;
    logic signed [25:0] vel_x_sum, vel_y_sum;
    logic signed [23:0] vel_x_new, vel_y_new;
    logic signed [24:0] vadj_x, vadj_y, vstep_x, vstep_y;
    logic signed [24:0] pos_x_sum, pos_y_sum;

    always_comb begin
        acc_x_sum = 25'(i_state.acc_x) + 25'(i_cfg.gravity_x);
        acc_y_sum = 25'(i_state.acc_y) + 25'(i_cfg.gravity_y);
        acc_x_new = sat24(26'(acc_x_sum));
        acc_y_new = sat24(26'(acc_y_sum));

        // The damping term is truncated toward zero: negative products get a bias.
        drag_s  = 17'(i_cfg.drag_factor);
        dprod_x = 41'(i_state.vel_x) * 41'(drag_s);
        dprod_y = 41'(i_state.vel_y) * 41'(drag_s);
        dadj_x  = dprod_x + (dprod_x[40] ? DBIAS : 41'sd0);
        dadj_y  = dprod_y + (dprod_y[40] ? DBIAS : 41'sd0);
        drag_x  = dadj_x[39:16];
        drag_y  = dadj_y[39:16];

        vel_x_sum = 26'(i_state.vel_x) + 26'(acc_x_new) - 26'(drag_x);
        vel_y_sum = 26'(i_state.vel_y) + 26'(acc_y_new) - 26'(drag_y);
        vel_x_new = sat24(vel_x_sum);
        vel_y_new = sat24(vel_y_sum);

        vadj_x  = 25'(vel_x_new) + (vel_x_new[23] ? VBIAS : 25'sd0);
        vadj_y  = 25'(vel_y_new) + (vel_y_new[23] ? VBIAS : 25'sd0);
        vstep_x = vadj_x >>> FRAC_BITS;
        vstep_y = vadj_y >>> FRAC_BITS;

        pos_x_sum = 25'(i_state.pos_x) + vstep_x;
        pos_y_sum = 25'(i_state.pos_y) + vstep_y;
    end

    // ---------------- collide ----------------
    logic signed [19:0] w_s, h_s, bw_s, bh_s, bx_s, by_s, px_s, py_s;
    logic signed [19:0] ex_a, ex_c, ey_c, dx2, dy2, adx2, ady2;
    logic               overlap;
    logic signed [DW-1:0] dpx_a, dpx_c, dpy_c;
    logic signed [13:0]   bw_m, bh_m;
    logic signed [DW+13:0] p_bw_y, p_bh_xa, p_bh_xc;
    logic signed [PW-1:0] cr_bd, cr_ac;
    logic signed [31:0]   v100_x, v100_y;
    logic                 sx_pos, sx_neg, sy_pos, sy_neg;
    logic [2:0]           edge_code;

    always_comb begin
        w_s  = 20'(i_cfg.body_width);
        h_s  = 20'(i_cfg.body_height);
        bw_s = 20'(i_item.block_w);
        bh_s = 20'(i_item.block_h);
        bx_s = 20'(i_item.block_x);
        by_s = 20'(i_item.block_y);
        px_s = 20'(i_state.pos_x);
        py_s = 20'(i_state.pos_y);

        // Centre distances at doubled scale.
        ex_a = (px_s <<< 1) + w_s - (bx_s <<< 1);
        ex_c = ex_a - (bw_s <<< 1);
        ey_c = (py_s <<< 1) + h_s - (by_s <<< 1) - (bh_s <<< 1);
        dx2  = ex_a - bw_s;
        dy2  = ey_c + bh_s;
        adx2 = dx2[19] ? -dx2 : dx2;
        ady2 = dy2[19] ? -dy2 : dy2;
        overlap = ((bw_s + w_s) > adx2) && ((bh_s + h_s) > ady2);

        // Previous centre relative to the block corners, doubled fixed point.
        dpx_a = (DW'(ex_a) <<< FRAC_BITS) - (DW'(i_state.vel_x) <<< 1);
        dpx_c = (DW'(ex_c) <<< FRAC_BITS) - (DW'(i_state.vel_x) <<< 1);
        dpy_c = (DW'(ey_c) <<< FRAC_BITS) - (DW'(i_state.vel_y) <<< 1);

        bw_m    = 14'(i_item.block_w);
        bh_m    = 14'(i_item.block_h);
        p_bw_y  = bw_m * dpy_c;
        p_bh_xa = bh_m * dpx_a;
        p_bh_xc = bh_m * dpx_c;
        cr_bd   = PW'(p_bw_y) + PW'(p_bh_xa);
        cr_ac   = PW'(p_bh_xc) - PW'(p_bw_y);

        // Motion direction with a dead zone of one hundredth.
        v100_x = 32'(i_state.vel_x) * 32'sd100;
        v100_y = 32'(i_state.vel_y) * 32'sd100;
        sx_pos = v100_x > ONE_Q;
        sx_neg = v100_x < NEG_ONE_Q;
        sy_pos = v100_y > ONE_Q;
        sy_neg = v100_y < NEG_ONE_Q;

        edge_code = EDGE_NONE;
        if (overlap) begin
            if (sx_pos && sy_neg) begin
                edge_code = cr_bd[PW-1] ? EDGE_RIGHT : EDGE_TOP;
            end else if (sx_neg && sy_pos) begin
                edge_code = cr_bd[PW-1] ? EDGE_BOTTOM : EDGE_LEFT;
            end else if (sx_neg && sy_neg) begin
                edge_code = cr_ac[PW-1] ? EDGE_TOP : EDGE_LEFT;
            end else if (sx_pos && sy_pos) begin
                edge_code = cr_ac[PW-1] ? EDGE_RIGHT : EDGE_BOTTOM;
            end else if (sx_pos) begin
                edge_code = EDGE_RIGHT;
            end else if (sx_neg) begin
                edge_code = EDGE_LEFT;
            end else if (sy_pos) begin
                edge_code = EDGE_BOTTOM;
            end else if (sy_neg) begin
                edge_code = EDGE_TOP;
            end
        end
    end

    // ---------------- select ----------------
    logic [2:0] hit;

    always_comb begin
        o_state = i_state;
        hit     = EDGE_NONE;
        if (i_item.cmd == CMD_TICK) begin
            o_state.acc_x = acc_x_new;
            o_state.acc_y = acc_y_new;
            o_state.vel_x = vel_x_new;
            o_state.vel_y = vel_y_new;
            o_state.pos_x = sat16(pos_x_sum);
            o_state.pos_y = sat16(pos_y_sum);
        end else begin
            hit = edge_code;
            case (edge_code)
                EDGE_TOP: begin
                    o_state.vel_y = 24'sd0;
                    o_state.pos_y = sat16(25'(by_s + bh_s));
                end
                EDGE_RIGHT: begin
                    o_state.vel_x = 24'sd0;
                    o_state.pos_x = sat16(25'(bx_s - w_s));
                end
                EDGE_BOTTOM: begin
                    o_state.vel_y = 24'sd0;
                    o_state.pos_y = sat16(25'(by_s - h_s));
                end
                EDGE_LEFT: begin
                    o_state.vel_x = 24'sd0;
                    o_state.pos_x = sat16(25'(bx_s + bw_s));
                end
                default: begin
                end
            endcase
        end

        o_result.hit_edge = hit;
        o_result.body_x   = o_state.pos_x;
        o_result.body_y   = o_state.pos_y;
        o_result.vel_x    = o_state.vel_x;
        o_result.vel_y    = o_state.vel_y;
    end

endmodule
